[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the band-split saturator.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property at every rising clock edge outside reset.
`define CBSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define CBSS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) \
        else $error("assertion failed");

`else

`define CBSS_ASSERT(label, clk, rst_n, prop)
`define CBSS_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

[hdl/cbss_pkg.sv]
// Package of the cascaded band-split saturator: sizes, types, constants and
// the fixed-point helper functions. It depends on nothing else.
`default_nettype none

package cbss_pkg;

    localparam int MAX_STAGES  = 16;
    localparam int BAND_COUNT  = 12;
    localparam int SAMPLE_BITS = 24;
    localparam int WORK_FRAC   = 24;

    localparam int DEPTH     = MAX_STAGES * BAND_COUNT;
    localparam int MEM_DEPTH = 2 * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int BAND_W    = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int STAGE_W   = $clog2(MAX_STAGES + 1);

    localparam int SINE_STEPS = 5;
    localparam int SINE_W     = $clog2(SINE_STEPS);

    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int WIDE_W = PROD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Sample scaling between the port format and the Q8.24 working format.
    localparam int IN_UP = (SAMPLE_BITS - 2 <= WORK_FRAC) ? WORK_FRAC - (SAMPLE_BITS - 2) : 0;
    localparam int IN_DN = (SAMPLE_BITS - 2 > WORK_FRAC) ? (SAMPLE_BITS - 2) - WORK_FRAC : 0;

    typedef logic signed [31:0]            t_word;
    typedef logic signed [OPND_W-1:0]      t_opnd;
    typedef logic signed [WIDE_W-1:0]      t_wide;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAINS_LOW  = 3'd0,
        CFG_GAINS_MID  = 3'd1,
        CFG_GAINS_HIGH = 3'd2,
        CFG_DRIVE      = 3'd3,
        CFG_PAD        = 3'd4,
        CFG_STAGES     = 3'd5,
        CFG_FIRST_COEF = 3'd6,
        CFG_TUNE       = 3'd7
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_CH_START, S_STG_START,
        S_B_RD, S_B_LD, S_B_1, S_B_2, S_B_3, S_B_4, S_B_5,
        S_B_6, S_B_7, S_B_8, S_B_9, S_B_10,
        S_STG_SUM, S_STG_DRV, S_STG_DRVR,
        S_FIN, S_PAD, S_PAD_R,
        S_SN_IN, S_SN_SQ, S_SN_Z, S_SN_ZP, S_SN_W, S_SN_RM, S_SN_Q, S_SN_FIX,
        S_SN_XP, S_SN_OUT, S_DONE
    } t_state;

    localparam logic [63:0] GAINS_LOW_RST  = 64'd4611756388245323776;
    localparam logic [63:0] GAINS_MID_RST  = 64'd4611756388245323776;
    localparam logic [47:0] GAINS_HIGH_RST = 48'd70369817935872;
    localparam logic [14:0] DRIVE_RST      = 15'd16384;
    localparam logic [14:0] PAD_RST        = 15'd16384;
    localparam logic [4:0]  STAGES_RST     = 5'd11;
    localparam logic [14:0] FIRST_COEF_RST = 15'd15237;
    localparam logic [15:0] TUNE_RST       = 16'd40862;

    localparam logic [14:0] UNITY_Q14   = 15'd16384;
    localparam logic [15:0] UNITY_GAIN  = 16'd16384;
    localparam t_wide       ONE_Q30     = 67'sd1073741824;
    localparam t_opnd       ONE_OPND    = 33'sd1073741824;
    localparam t_wide       PI_Q24      = 67'sd52707179;
    localparam t_wide       HALF_PI_Q24 = 67'sd26353589;
    localparam t_wide       MAX32       = 67'sd2147483647;
    localparam t_wide       MIN32       = -67'sd2147483648;
    localparam t_wide       OUT_MAX     = t_wide'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam t_wide       OUT_MIN     = -OUT_MAX - 67'sd1;

    // Divisors of the sine series and floor(2^33 / divisor) for each.
    localparam logic [6:0] SINE_DIV [SINE_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam t_opnd SINE_RECIP [SINE_STEPS] = '{
        33'sd78090314, 33'sd119304647, 33'sd204522252, 33'sd429496729, 33'sd1431655765
    };
    localparam int RECIP_SHIFT = 33;

    // Arithmetic shift right with rounding half up; s is at least one.
    function automatic t_wide rnd_shr(input t_wide v, input int unsigned s);
        t_wide half;
        half = t_wide'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic t_word sat32(input t_wide v);
        t_wide r;
        r = v;
        if (v > MAX32) r = MAX32;
        else if (v < MIN32) r = MIN32;
        return r[31:0];
    endfunction

    function automatic logic [15:0] band_gain(input logic [63:0] gl, input logic [63:0] gm,
                                              input logic [47:0] gh,
                                              input logic [BAND_W-1:0] b);
        int idx;
        logic [15:0] g;
        idx = int'(b);
        if (idx < 4) g = gl[16*idx +: 16];
        else if (idx < 8) g = gm[16*(idx-4) +: 16];
        else if (idx < 11) g = gh[16*(idx-8) +: 16];
        else g = UNITY_GAIN;
        return g;
    endfunction

    function automatic t_word to_work(input t_sample s);
        t_wide v;
        v = t_wide'(s) <<< IN_UP;
        if (IN_DN > 0) v = rnd_shr(v, IN_DN);
        return v[31:0];
    endfunction

    function automatic t_sample from_work(input t_word x);
        t_wide v;
        v = t_wide'(x) <<< IN_DN;
        if (IN_UP > 0) v = rnd_shr(v, IN_UP);
        if (v > OUT_MAX) v = OUT_MAX;
        else if (v < OUT_MIN) v = OUT_MIN;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Clamps the sine argument to +-pi and folds it into +-pi/2.
    function automatic t_opnd clamp_fold(input t_wide v);
        t_wide x;
        x = v;
        if (x > PI_Q24) x = PI_Q24;
        else if (x < -PI_Q24) x = -PI_Q24;
        if (x > HALF_PI_Q24) x = PI_Q24 - x;
        else if (x < -HALF_PI_Q24) x = -PI_Q24 - x;
        return x[OPND_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/cbss_mul.sv]
// Shared signed multiplier of the band-split saturator with a registered
// product. Depends on cbss_pkg.
`default_nettype none

module cbss_mul (
    input  logic                  i_clk,
    input  cbss_pkg::t_opnd       i_a,
    input  cbss_pkg::t_opnd       i_b,
    output cbss_pkg::t_wide       o_prod
);
    import cbss_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = t_wide'(r_prod);

endmodule

`default_nettype wire

[hdl/cascaded_band_split_saturator_unit.sv]
// Top level of the cascaded band-split saturator: sequencer, state memory,
// configuration registers and the shared multiplier. Depends on cbss_pkg,
// cbss_mul and assert_macros.svh.
//
// Usage: one stereo frame enters on the input channel (valid/ready) and one
// stereo frame leaves on the output channel. Each channel runs through the
// configured number of stages n (at most 16); each stage walks 12 bands
// through one shared multiplier and then evaluates a sine series on it.
// Bands, sine steps, stages and channels all run in turn through the one
// shared multiplier. The block holds one frame at a time and takes the
// next input beat as soon as the frame is done, even while the last
// result still waits in the output register.
// After reset a clearing pass zeroes the whole band state memory;
// input ready stays low meanwhile. Configuration writes are taken at any
// time and should only be issued while no frame is in flight. When the
// receiver stalls, the result waits in the output register and a following
// frame waits at its end until the register is free.
`default_nettype none
`include "assert_macros.svh"

module cascaded_band_split_saturator_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [cbss_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [cbss_pkg::SAMPLE_BITS-1:0] i_right_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cbss_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [cbss_pkg::SAMPLE_BITS-1:0] o_right_out,
    input  logic                                   i_cfg_wr_en,
    input  logic [cbss_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cbss_pkg::CFG_DATA_W-1:0]        i_cfg_wr_data
);
    import cbss_pkg::*;

    // Configuration registers.
    logic [63:0] r_gains_low, r_gains_mid;
    logic [47:0] r_gains_high;
    logic [14:0] r_drive, r_pad, r_first;
    logic [4:0]  r_stages;
    logic [15:0] r_tune;

    // Sequencer state.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_addr;
    logic [BAND_W-1:0]   r_band;
    logic [STAGE_W-1:0]  r_stage;
    logic [SINE_W-1:0]   r_k;
    logic                r_ch, r_final, r_out_valid;

    // Datapath registers.
    t_sample r_in_left, r_in_right, r_left_res, r_right_res, r_left_out, r_right_out;
    t_word   r_x, r_lev, r_d, r_a, r_t, r_tom, r_nb, r_dg, r_acc;
    t_wide   r_tmp, r_sin_in;
    t_opnd   r_fr, r_sx, r_z, r_p, r_w, r_q;
    logic [63:0] r_rdata;
    logic [63:0] mem [MEM_DEPTH];

    // Combinational signals.
    t_opnd  mul_a, mul_b, w_om;
    t_wide  w_prod, w_div, w_rem, w_qfix;
    t_word  w_sine;
    logic   mem_we, mem_re;
    logic [63:0] mem_wdata;
    logic [STAGE_W-1:0] w_nstg;
    logic   w_in_acc, w_out_free, w_pad_on;

    cbss_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (w_prod)
    );

    assign w_om       = ONE_OPND - r_fr;
    assign w_nstg     = (int'(r_stages) > MAX_STAGES) ? STAGE_W'(MAX_STAGES)
                                                      : STAGE_W'(r_stages);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pad_on   = r_pad < UNITY_Q14;
    assign w_div      = t_wide'(SINE_DIV[r_k]);
    assign w_rem      = t_wide'(r_w) - t_wide'(r_q) * w_div;
    assign w_qfix     = (w_rem >= w_div) ? t_wide'(r_q) + t_wide'(1) : t_wide'(r_q);
    assign w_sine     = sat32(rnd_shr(w_prod, 30));

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_addr == ADDR_W'(MEM_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:      if (w_in_acc) n_state = S_CH_START;
            S_CH_START:  n_state = (w_nstg == '0) ? S_FIN : S_STG_START;
            S_STG_START: n_state = S_B_RD;
            S_B_RD:      n_state = S_B_LD;
            S_B_LD:      n_state = S_B_1;
            S_B_1:       n_state = S_B_2;
            S_B_2:       n_state = S_B_3;
            S_B_3:       n_state = S_B_4;
            S_B_4:       n_state = S_B_5;
            S_B_5:       n_state = S_B_6;
            S_B_6:       n_state = S_B_7;
            S_B_7:       n_state = S_B_8;
            S_B_8:       n_state = S_B_9;
            S_B_9:       n_state = S_B_10;
            S_B_10:      n_state = (r_band == BAND_W'(BAND_COUNT - 1)) ? S_STG_SUM : S_B_RD;
            S_STG_SUM:   n_state = S_STG_DRV;
            S_STG_DRV:   n_state = S_STG_DRVR;
            S_STG_DRVR:  n_state = S_SN_IN;
            S_FIN:       n_state = w_pad_on ? S_PAD : S_SN_IN;
            S_PAD:       n_state = S_PAD_R;
            S_PAD_R:     n_state = S_SN_IN;
            S_SN_IN:     n_state = S_SN_SQ;
            S_SN_SQ:     n_state = S_SN_Z;
            S_SN_Z:      n_state = S_SN_ZP;
            S_SN_ZP:     n_state = S_SN_W;
            S_SN_W:      n_state = S_SN_RM;
            S_SN_RM:     n_state = S_SN_Q;
            S_SN_Q:      n_state = S_SN_FIX;
            S_SN_FIX:    n_state = (r_k == SINE_W'(SINE_STEPS - 1)) ? S_SN_XP : S_SN_ZP;
            S_SN_XP:     n_state = S_SN_OUT;
            S_SN_OUT: begin
                if (!r_final) n_state = (r_stage == w_nstg - 1'b1) ? S_FIN : S_STG_START;
                else n_state = r_ch ? S_DONE : S_CH_START;
            end
            S_DONE:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_CLEAR;
        endcase
    end

    // Multiplier operands, memory controls and input ready.
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wdata  = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:    mem_we = 1'b1;
            S_IDLE:     o_in_ready = 1'b1;
            S_B_RD:     mem_re = 1'b1;
            S_B_LD: begin
                mul_a = t_opnd'($signed(r_rdata[63:32]));
                mul_b = w_om;
            end
            S_B_1: begin
                mul_a = t_opnd'(r_d);
                mul_b = r_fr;
            end
            S_B_3: begin
                mul_a = t_opnd'(r_a);
                mul_b = r_fr;
            end
            S_B_4: begin
                mul_a = t_opnd'(r_x);
                mul_b = r_fr;
            end
            S_B_5: begin
                mul_a = t_opnd'(r_t);
                mul_b = w_om;
            end
            S_B_7: begin
                mul_a = t_opnd'(r_nb);
                mul_b = r_fr;
            end
            S_B_8: begin
                mul_a     = t_opnd'(r_dg);
                mul_b     = t_opnd'($signed({1'b0,
                                band_gain(r_gains_low, r_gains_mid, r_gains_high, r_band)}));
                mem_we    = 1'b1;
                mem_wdata = {r_a, sat32(t_wide'(r_tom) + rnd_shr(w_prod, 30))};
            end
            S_B_9: begin
                mul_a = r_fr;
                mul_b = t_opnd'($signed({1'b0, r_tune}));
            end
            S_STG_DRV: begin
                mul_a = t_opnd'(r_acc);
                mul_b = t_opnd'($signed({1'b0, r_drive}));
            end
            S_PAD: begin
                mul_a = t_opnd'(r_x);
                mul_b = t_opnd'($signed({1'b0, r_pad}));
            end
            S_SN_SQ: begin
                mul_a = r_sx;
                mul_b = r_sx;
            end
            S_SN_ZP: begin
                mul_a = r_z;
                mul_b = r_p;
            end
            S_SN_RM: begin
                mul_a = r_w;
                mul_b = SINE_RECIP[r_k];
            end
            S_SN_XP: begin
                mul_a = r_sx;
                mul_b = r_p;
            end
            default: ;
        endcase
    end

    // State memory: {velocity, level} per channel, stage and band.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_addr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[r_addr];
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_band       <= '0;
            r_stage      <= '0;
            r_k          <= '0;
            r_ch         <= 1'b0;
            r_final      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_gains_low  <= GAINS_LOW_RST;
            r_gains_mid  <= GAINS_MID_RST;
            r_gains_high <= GAINS_HIGH_RST;
            r_drive      <= DRIVE_RST;
            r_pad        <= PAD_RST;
            r_stages     <= STAGES_RST;
            r_first      <= FIRST_COEF_RST;
            r_tune       <= TUNE_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_GAINS_LOW:  r_gains_low  <= i_cfg_wr_data;
                    CFG_GAINS_MID:  r_gains_mid  <= i_cfg_wr_data;
                    CFG_GAINS_HIGH: r_gains_high <= i_cfg_wr_data[47:0];
                    CFG_DRIVE:      r_drive      <= i_cfg_wr_data[14:0];
                    CFG_PAD:        r_pad        <= i_cfg_wr_data[14:0];
                    CFG_STAGES:     r_stages     <= i_cfg_wr_data[4:0];
                    CFG_FIRST_COEF: r_first      <= i_cfg_wr_data[14:0];
                    CFG_TUNE:       r_tune       <= i_cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR:     r_addr <= r_addr + 1'b1;
                S_IDLE:      r_ch <= 1'b0;
                S_CH_START: begin
                    r_addr  <= r_ch ? ADDR_W'(DEPTH) : '0;
                    r_stage <= '0;
                end
                S_STG_START: r_band <= '0;
                S_B_10: begin
                    r_addr <= r_addr + 1'b1;
                    r_band <= r_band + 1'b1;
                end
                S_STG_DRVR:  r_final <= 1'b0;
                S_FIN:       r_final <= 1'b1;
                S_SN_Z:      r_k <= '0;
                S_SN_FIX:    r_k <= r_k + 1'b1;
                S_SN_OUT: begin
                    if (!r_final) r_stage <= r_stage + 1'b1;
                    else r_ch <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_in_left  <= i_left_sample;
                    r_in_right <= i_right_sample;
                end
            end
            S_CH_START:  r_x <= to_work(r_ch ? r_in_right : r_in_left);
            S_STG_START: begin
                r_fr  <= t_opnd'({2'b00, r_first, 16'h0000});
                r_acc <= '0;
            end
            S_B_LD: begin
                r_lev <= r_rdata[31:0];
                r_d   <= sat32(t_wide'(r_x) - t_wide'($signed(r_rdata[31:0])));
            end
            S_B_1:  r_tmp <= rnd_shr(w_prod, 30);
            S_B_2:  r_a <= sat32(r_tmp + rnd_shr(w_prod, 30));
            S_B_4:  r_t <= sat32(t_wide'(r_lev) + rnd_shr(w_prod, 30));
            S_B_5:  r_tmp <= rnd_shr(w_prod, 30);
            S_B_6: begin
                r_tom <= sat32(rnd_shr(w_prod, 30));
                r_nb  <= sat32(rnd_shr(w_prod, 30) + r_tmp);
            end
            S_B_7:  r_dg <= sat32(t_wide'(r_x) - t_wide'(r_nb));
            S_B_9: begin
                r_acc <= sat32(t_wide'(r_acc) + rnd_shr(w_prod, 14));
                r_x   <= r_nb;
            end
            S_B_10: begin
                r_fr <= t_opnd'(rnd_shr(w_prod, 16));
            end
            S_STG_SUM:  r_acc <= sat32(t_wide'(r_acc) + t_wide'(r_x));
            S_STG_DRVR: r_sin_in <= rnd_shr(w_prod, 14);
            S_FIN:      r_sin_in <= t_wide'(r_x);
            S_PAD_R:    r_sin_in <= rnd_shr(w_prod, 14);
            S_SN_IN:    r_sx <= clamp_fold(r_sin_in);
            S_SN_Z: begin
                r_z <= t_opnd'(rnd_shr(w_prod, 18));
                r_p <= ONE_OPND;
            end
            S_SN_W:   r_w <= t_opnd'((w_prod + (w_div <<< 29)) >>> 30);
            S_SN_Q:   r_q <= t_opnd'(w_prod >>> RECIP_SHIFT);
            S_SN_FIX: r_p <= t_opnd'(ONE_Q30 - w_qfix);
            S_SN_OUT: begin
                r_x <= w_sine;
                if (r_final) begin
                    if (r_ch) r_right_res <= from_work(w_sine);
                    else r_left_res <= from_work(w_sine);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_left_out  <= r_left_res;
                    r_right_out <= r_right_res;
                end
            end
            default: ;
        endcase
    end

    // The sine polynomial must stay inside (0, 1] before the final multiply.
    `CBSS_ASSERT(a_sine_poly_range, i_clk, i_rst_n, (r_state == S_SN_XP) |-> (r_p > t_opnd'(0) && r_p <= ONE_OPND))
    // The reciprocal quotient is off by at most one, so one correction suffices.
    `CBSS_ASSERT(a_recip_correction, i_clk, i_rst_n, (r_state == S_SN_FIX) |-> (w_rem >= t_wide'(0) && w_rem < (w_div <<< 1)))
    // An accepted beat always starts with the left channel.
    `CBSS_ASSERT_NEXT(a_start_left, i_clk, i_rst_n, w_in_acc, (r_state == S_CH_START && r_ch == 1'b0))

endmodule

`default_nettype wire
